// ===== rtl/core/msl_pkg.sv =====
// msl_pkg: shared constants and types for the muscl slope limiter
// used by the top level and the port checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package msl_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int W_ONE      = 16384;
  localparam int CFG_W      = 16;
  localparam int IDX_W      = 1;

  typedef enum logic [IDX_W-1:0] {
    REG_SLOPE_WEIGHT   = 1'b0,
    REG_LIMITER_CHOICE = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    LIM_MINMOD     = 2'd0,
    LIM_SUPERBEE   = 2'd1,
    LIM_VAN_LEER   = 2'd2,
    LIM_VAN_ALBADA = 2'd3
  } limiter_t;

endpackage

`default_nettype wire

// ===== rtl/core/msl_div_cell.sv =====
// msl_div_cell: one registered restoring division step
// produces one quotient bit per cycle while en is high; no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module msl_div_cell #(
  parameter int REM_W = 33,
  parameter int NUM_W = 31,
  parameter int QUO_W = 31
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [REM_W-1:0] rem_prev,
  input  wire logic [REM_W-1:0] den_prev,
  input  wire logic [NUM_W-1:0] num_prev,
  input  wire logic [QUO_W-1:0] quo_prev,
  output logic      [REM_W-1:0] rem,
  output logic      [REM_W-1:0] den,
  output logic      [NUM_W-1:0] num,
  output logic      [QUO_W-1:0] quo
);

  logic [REM_W-1:0] shifted;
  logic [REM_W-1:0] diff;
  logic             take;

  always_comb begin
    shifted = {rem_prev[REM_W-2:0], num_prev[NUM_W-1]};
    take    = (shifted >= den_prev);
    diff    = shifted - den_prev;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= take ? diff : shifted;
      den <= den_prev;
      num <= num_prev << 1;
      quo <= {quo_prev[QUO_W-2:0], take};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/msl_delay_line.sv =====
// msl_delay_line: valid and sideband registers that run beside a divider chain
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module msl_delay_line #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             valid_prev,
  input  wire logic [WIDTH-1:0] data_prev,
  output logic                  valid,
  output logic      [WIDTH-1:0] data
);

  logic [DEPTH-1:0] vpipe;
  logic [WIDTH-1:0] dpipe [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[DEPTH-2:0], valid_prev};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dpipe[0] <= data_prev;
      for (int i = 1; i < DEPTH; i++) begin
        dpipe[i] <= dpipe[i-1];
      end
    end
  end

  assign valid = vpipe[DEPTH-1];
  assign data  = dpipe[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/core/muscl_slope_limiter.sv =====
// muscl_slope_limiter: pipelined slope limiter, one transaction per cycle while no result is held
// each result passes the front end, ratio divide, limiter divides and final scaling into the output register
// the ratio divide runs through 31 division cells, the limiter divides through 18
// all stages advance together; a held result stalls the whole pipe
// reset clears all valid flags, weight to 0 and limiter to minmod
// depends on msl_pkg, msl_div_cell, msl_delay_line
`timescale 1ns / 1ps
`default_nettype none

module muscl_slope_limiter
  import msl_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [IDX_W-1:0]             cfg_index,
  input  wire logic [CFG_W-1:0]             cfg_data,
  input  wire logic                         diff_valid,
  output logic                              diff_stall,
  input  wire logic signed [DATA_WIDTH-1:0] left_diff,
  input  wire logic signed [DATA_WIDTH-1:0] right_diff,
  output logic                              slope_valid,
  input  wire logic                         slope_stall,
  output logic signed [DATA_WIDTH-1:0]      limited_slope
);

  localparam int R_STEPS = 31;
  localparam int X_STEPS = 18;
  localparam int R_REM_W = 33;
  localparam int X_REM_W = 48;
  localparam int V_REM_W = 33;
  localparam int A_REM_W = 64;
  localparam int DQ_W    = 49;
  localparam int MAG_W   = 47;
  localparam int XI_W    = 18;
  localparam int PROD_W  = MAG_W + XI_W;
  localparam int RS_W    = DQ_W + 2;
  localparam int XS_W    = DQ_W + R_STEPS + 2;

  localparam logic [30:0]       UR_MAX  = 31'h7FFF_FFFF;
  localparam logic [30:0]       ONE_R   = 31'(1 << FRAC_BITS);
  localparam logic [30:0]       HALF_R  = 31'(1 << (FRAC_BITS - 1));
  localparam logic [XI_W-1:0]   ONE_X   = XI_W'(1 << FRAC_BITS);
  localparam logic [XI_W-1:0]   TWO_X   = XI_W'(2 << FRAC_BITS);
  localparam logic [46:0]       CAP_DEN = 47'(1 << 29);

  logic signed [15:0] slope_weight;
  limiter_t           limiter_choice;

  always_ff @(posedge clk) begin
    if (rst) begin
      slope_weight   <= '0;
      limiter_choice <= LIM_MINMOD;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_SLOPE_WEIGHT:   slope_weight   <= cfg_data;
        REG_LIMITER_CHOICE: limiter_choice <= limiter_t'(cfg_data[1:0]);
      endcase
    end
  end

  logic signed [15:0] w_sat;
  logic [15:0]        a_w;
  logic [15:0]        b_w;

  always_comb begin
    if (slope_weight > 16'sd16384) begin
      w_sat = 16'sd16384;
    end else if (slope_weight < -16'sd16384) begin
      w_sat = -16'sd16384;
    end else begin
      w_sat = slope_weight;
    end
    a_w = 16'(W_ONE) + w_sat;
    b_w = 16'(W_ONE) - w_sat;
  end

  logic adv;
  assign adv        = !slope_valid || !slope_stall;
  assign diff_stall = !adv;

  // front end
  logic                         v1, v2, v3;
  logic signed [DATA_WIDTH-1:0] left1, right1;
  logic signed [DQ_W-1:0]       prod_a2, prod_b2, dq3;
  logic [DATA_WIDTH-1:0]        mag_l2, mag_r2;
  logic                         pos2, pos3, sat3;
  logic [R_REM_W-1:0]           r_rem3, r_den3;
  logic [R_STEPS-1:0]           r_num3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= diff_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      left1   <= left_diff;
      right1  <= right_diff;
      prod_a2 <= $signed({1'b0, a_w}) * left1;
      prod_b2 <= $signed({1'b0, b_w}) * right1;
      mag_l2  <= left1[DATA_WIDTH-1] ? (~left1 + 32'd1) : left1;
      mag_r2  <= right1[DATA_WIDTH-1] ? (~right1 + 32'd1) : right1;
      pos2    <= (left1 != '0) && (right1 != '0) &&
                 (left1[DATA_WIDTH-1] == right1[DATA_WIDTH-1]);
      dq3     <= prod_a2 + prod_b2;
      sat3    <= ({15'd0, mag_l2} >= {mag_r2, 15'd0});
      pos3    <= pos2;
      r_rem3  <= {16'd0, mag_l2[31:15]};
      r_den3  <= {1'b0, mag_r2};
      r_num3  <= {mag_l2[14:0], 16'd0};
    end
  end

  // ratio divide chain
  logic [R_REM_W-1:0] rd_rem [R_STEPS+1];
  logic [R_REM_W-1:0] rd_den [R_STEPS+1];
  logic [R_STEPS-1:0] rd_num [R_STEPS+1];
  logic [R_STEPS-1:0] rd_quo [R_STEPS+1];

  assign rd_rem[0] = r_rem3;
  assign rd_den[0] = r_den3;
  assign rd_num[0] = r_num3;
  assign rd_quo[0] = '0;

  for (genvar i = 0; i < R_STEPS; i++) begin : g_rdiv
    msl_div_cell #(
      .REM_W(R_REM_W),
      .NUM_W(R_STEPS),
      .QUO_W(R_STEPS)
    ) u_cell (
      .clk      (clk),
      .en       (adv),
      .rem_prev (rd_rem[i]),
      .den_prev (rd_den[i]),
      .num_prev (rd_num[i]),
      .quo_prev (rd_quo[i]),
      .rem      (rd_rem[i+1]),
      .den      (rd_den[i+1]),
      .num      (rd_num[i+1]),
      .quo      (rd_quo[i+1])
    );
  end

  logic            rs_valid;
  logic [RS_W-1:0] rs_data;

  msl_delay_line #(
    .WIDTH(RS_W),
    .DEPTH(R_STEPS)
  ) u_rside (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .valid_prev (v3),
    .data_prev  ({dq3, sat3, pos3}),
    .valid      (rs_valid),
    .data       (rs_data)
  );

  // ratio to limiter operands
  logic                   v4, v5, v6;
  logic [30:0]            ur4, ur5, ur6;
  logic signed [DQ_W-1:0] dq4, dq5, dq6;
  logic                   pos4, pos5, pos6, cap6;
  logic [46:0]            aur5;
  logic [61:0]            ur2_5;
  logic [46:0]            den_x;
  logic [62:0]            va_n;
  logic [62:0]            va_d;
  logic [X_REM_W-1:0]     x_den6;
  logic [V_REM_W-1:0]     v_rem6, v_den6;
  logic [X_STEPS-1:0]     v_num6, a_num6;
  logic [A_REM_W-1:0]     a_rem6, a_den6;

  always_comb begin
    den_x = {15'd0, b_w, 16'd0} + aur5;
    va_n  = {16'd0, ur5, 16'd0} + {1'b0, ur2_5};
    va_d  = {1'b0, ur2_5} + 63'h1_0000_0000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v4 <= rs_valid;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ur4    <= rs_data[1] ? UR_MAX : rd_quo[R_STEPS];
      pos4   <= rs_data[0] && (rs_data[1] || (rd_quo[R_STEPS] != '0));
      dq4    <= rs_data[RS_W-1:2];
      aur5   <= a_w * ur4;
      ur2_5  <= ur4 * ur4;
      ur5    <= ur4;
      dq5    <= dq4;
      pos5   <= pos4;
      x_den6 <= {1'b0, den_x};
      cap6   <= (den_x <= CAP_DEN);
      v_rem6 <= {3'd0, ur5[30:1]};
      v_den6 <= {2'd0, ur5} + 33'h1_0000;
      v_num6 <= {ur5[0], 17'd0};
      a_rem6 <= {3'd0, va_n[62:2]};
      a_den6 <= {1'b0, va_d};
      a_num6 <= {va_n[1:0], 16'd0};
      ur6    <= ur5;
      dq6    <= dq5;
      pos6   <= pos5;
    end
  end

  // limiter divide chains
  logic [X_REM_W-1:0] xd_rem [X_STEPS+1];
  logic [X_REM_W-1:0] xd_den [X_STEPS+1];
  logic [X_STEPS-1:0] xd_num [X_STEPS+1];
  logic [X_STEPS-1:0] xd_quo [X_STEPS+1];
  logic [V_REM_W-1:0] vd_rem [X_STEPS+1];
  logic [V_REM_W-1:0] vd_den [X_STEPS+1];
  logic [X_STEPS-1:0] vd_num [X_STEPS+1];
  logic [X_STEPS-1:0] vd_quo [X_STEPS+1];
  logic [A_REM_W-1:0] ad_rem [X_STEPS+1];
  logic [A_REM_W-1:0] ad_den [X_STEPS+1];
  logic [X_STEPS-1:0] ad_num [X_STEPS+1];
  logic [X_STEPS-1:0] ad_quo [X_STEPS+1];

  assign xd_rem[0] = X_REM_W'(CAP_DEN);
  assign xd_den[0] = x_den6;
  assign xd_num[0] = '0;
  assign xd_quo[0] = '0;
  assign vd_rem[0] = v_rem6;
  assign vd_den[0] = v_den6;
  assign vd_num[0] = v_num6;
  assign vd_quo[0] = '0;
  assign ad_rem[0] = a_rem6;
  assign ad_den[0] = a_den6;
  assign ad_num[0] = a_num6;
  assign ad_quo[0] = '0;

  for (genvar i = 0; i < X_STEPS; i++) begin : g_ldiv
    msl_div_cell #(
      .REM_W(X_REM_W),
      .NUM_W(X_STEPS),
      .QUO_W(X_STEPS)
    ) u_xcell (
      .clk      (clk),
      .en       (adv),
      .rem_prev (xd_rem[i]),
      .den_prev (xd_den[i]),
      .num_prev (xd_num[i]),
      .quo_prev (xd_quo[i]),
      .rem      (xd_rem[i+1]),
      .den      (xd_den[i+1]),
      .num      (xd_num[i+1]),
      .quo      (xd_quo[i+1])
    );

    msl_div_cell #(
      .REM_W(V_REM_W),
      .NUM_W(X_STEPS),
      .QUO_W(X_STEPS)
    ) u_vcell (
      .clk      (clk),
      .en       (adv),
      .rem_prev (vd_rem[i]),
      .den_prev (vd_den[i]),
      .num_prev (vd_num[i]),
      .quo_prev (vd_quo[i]),
      .rem      (vd_rem[i+1]),
      .den      (vd_den[i+1]),
      .num      (vd_num[i+1]),
      .quo      (vd_quo[i+1])
    );

    msl_div_cell #(
      .REM_W(A_REM_W),
      .NUM_W(X_STEPS),
      .QUO_W(X_STEPS)
    ) u_acell (
      .clk      (clk),
      .en       (adv),
      .rem_prev (ad_rem[i]),
      .den_prev (ad_den[i]),
      .num_prev (ad_num[i]),
      .quo_prev (ad_quo[i]),
      .rem      (ad_rem[i+1]),
      .den      (ad_den[i+1]),
      .num      (ad_num[i+1]),
      .quo      (ad_quo[i+1])
    );
  end

  logic            xs_valid;
  logic [XS_W-1:0] xs_data;

  msl_delay_line #(
    .WIDTH(XS_W),
    .DEPTH(X_STEPS)
  ) u_xside (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .valid_prev (v6),
    .data_prev  ({dq6, ur6, pos6, cap6}),
    .valid      (xs_valid),
    .data       (xs_data)
  );

  // limiter select and final scaling
  logic signed [DQ_W-1:0] dq_s;
  logic [30:0]            ur_s;
  logic [XI_W-1:0]        xir;
  logic [XI_W-1:0]        sb_min;
  logic [XI_W-1:0]        xi;
  logic [DQ_W-1:0]        dq_abs;

  always_comb begin
    dq_s   = xs_data[XS_W-1 -: DQ_W];
    ur_s   = xs_data[R_STEPS+1:2];
    xir    = xs_data[0] ? '1 : xd_quo[X_STEPS];
    dq_abs = dq_s[DQ_W-1] ? (~dq_s + 49'd1) : dq_s;
    sb_min = ({13'd0, xir} < ur_s) ? xir : ur_s[XI_W-1:0];
    if (sb_min > TWO_X) begin
      sb_min = TWO_X;
    end
    case (limiter_choice)
      LIM_MINMOD: begin
        if (ur_s <= ONE_R) begin
          xi = ur_s[XI_W-1:0];
        end else begin
          xi = (xir < ONE_X) ? xir : ONE_X;
        end
      end
      LIM_SUPERBEE: begin
        if (ur_s <= HALF_R) begin
          xi = {ur_s[XI_W-2:0], 1'b0};
        end else if (ur_s <= ONE_R) begin
          xi = ONE_X;
        end else begin
          xi = sb_min;
        end
      end
      LIM_VAN_LEER: begin
        xi = (vd_quo[X_STEPS] < xir) ? vd_quo[X_STEPS] : xir;
      end
      default: begin
        xi = (ad_quo[X_STEPS] < xir) ? ad_quo[X_STEPS] : xir;
      end
    endcase
  end

  logic              v7, v8;
  logic [XI_W-1:0]   xi7;
  logic [MAG_W-1:0]  mag7;
  logic              neg7, pos7, neg8, pos8;
  logic [PROD_W-1:0] prod8;
  logic [PROD_W-1:0] rounded;
  logic [33:0]       res;
  logic [DATA_WIDTH-1:0] slope_next;

  always_comb begin
    rounded = prod8 + (PROD_W'(1) << 30);
    res     = rounded[PROD_W-1:31];
    if (!pos8) begin
      slope_next = '0;
    end else if (neg8) begin
      if (res > 34'h0_8000_0000) begin
        slope_next = 32'h8000_0000;
      end else begin
        slope_next = ~res[31:0] + 32'd1;
      end
    end else if (res > 34'h0_7FFF_FFFF) begin
      slope_next = 32'h7FFF_FFFF;
    end else begin
      slope_next = res[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7          <= 1'b0;
      v8          <= 1'b0;
      slope_valid <= 1'b0;
    end else if (adv) begin
      v7          <= xs_valid;
      v8          <= v7;
      slope_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xi7           <= xi;
      mag7          <= dq_abs[MAG_W-1:0];
      neg7          <= dq_s[DQ_W-1];
      pos7          <= xs_data[1];
      prod8         <= mag7 * xi7;
      neg8          <= neg7;
      pos8          <= pos7;
      limited_slope <= slope_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/msl_checker.sv =====
// msl_checker: port-level assertions for muscl_slope_limiter, bound to the top level
// depends on msl_pkg
`timescale 1ns / 1ps
`default_nettype none

module msl_checker
  import msl_pkg::*;
(
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         diff_valid,
  input wire logic                         diff_stall,
  input wire logic                         slope_valid,
  input wire logic                         slope_stall,
  input wire logic signed [DATA_WIDTH-1:0] limited_slope
);

  // held result keeps its transaction
  a_hold: assert property (@(posedge clk) disable iff (rst)
    slope_valid && slope_stall |=> slope_valid && $stable(limited_slope))
    else $error("held result changed");

  // input side stalls only behind a held result
  a_stall: assert property (@(posedge clk)
    diff_stall == (slope_valid && slope_stall))
    else $error("input stall does not follow output hold");

  a_reset: assert property (@(posedge clk)
    rst |=> !slope_valid)
    else $error("result valid after reset");

endmodule

bind muscl_slope_limiter msl_checker u_msl_checker (.*);

`default_nettype wire
